@@ rtl/q4_block_quantized_matvec_assert.svh @@
// Assertion macros shared by the matvec RTL.
`ifndef Q4_BLOCK_QUANTIZED_MATVEC_ASSERT_SVH
`define Q4_BLOCK_QUANTIZED_MATVEC_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define Q4MV_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("q4mv: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define Q4MV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("q4mv: next-cycle check failed");

`endif

@@ rtl/q4mv_pkg.sv @@
// Shared widths, codes and constants for the 4-bit block matvec.
`default_nettype none

package q4mv_pkg;

  localparam int CMD_W       = 2;
  localparam int ACT_IDX_W   = 13;
  localparam int VAL_W       = 16;
  localparam int BYTE_W      = 8;
  localparam int SUM_W       = 48;
  localparam int ROW_W       = 16;
  localparam int BPR_W       = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int MAX_BLOCKS      = 256;
  localparam int BYTES_PER_BLOCK = 16;
  localparam int SYM_OFFSET      = 8;
  localparam int MINMAX_DIV      = 15;

  localparam int ACC_W      = 56;
  localparam int WEIGHT_W   = 22;
  localparam int PROD_W     = WEIGHT_W + VAL_W;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STEPS  = ACC_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_ACT = 2'd0,
    CMD_SCALES   = 2'd1,
    CMD_WEIGHT   = 2'd2
  } command_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORMAT         = 2'd0,
    REG_BLOCKS_PER_ROW = 2'd1,
    REG_ROWS_IN_USE    = 2'd2
  } cfg_reg_t;

endpackage

`default_nettype wire

@@ rtl/q4mv_if.sv @@
// Item and result channel interfaces for the 4-bit block matvec.
`default_nettype none

interface q4mv_item_if;
  logic                                 valid;
  logic                                 ready;
  logic [q4mv_pkg::CMD_W-1:0]           command;
  logic [q4mv_pkg::ACT_IDX_W-1:0]       act_index;
  logic signed [q4mv_pkg::VAL_W-1:0]    act_value;
  logic signed [q4mv_pkg::VAL_W-1:0]    scale_first;
  logic signed [q4mv_pkg::VAL_W-1:0]    scale_second;
  logic [q4mv_pkg::BYTE_W-1:0]          weight_byte;

  modport source (
    output valid, command, act_index, act_value, scale_first, scale_second,
           weight_byte,
    input  ready
  );
  modport sink (
    input  valid, command, act_index, act_value, scale_first, scale_second,
           weight_byte,
    output ready
  );
endinterface

interface q4mv_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [q4mv_pkg::SUM_W-1:0]    row_sum;
  logic [q4mv_pkg::ROW_W-1:0]           row_index;
  logic                                 last_row;

  modport source (output valid, row_sum, row_index, last_row, input ready);
  modport sink   (input valid, row_sum, row_index, last_row, output ready);
endinterface

`default_nettype wire

@@ rtl/q4_block_quantized_matvec.sv @@
// Top level: 4-bit block-quantized weight rows times a stored activation vector.
//
//   channel   dir  handshake      payload
//   items     in   valid/ready    command, act_index, act_value, scale_first,
//                                 scale_second, weight_byte
//   results   out  valid/ready    row_sum, row_index, last_row
//   cfg       in   cfg_write      cfg_index, cfg_data
//
// One item per cycle while input is open. Activations sit in two 4096x16 RAMs
// (even and odd element), read once per weight byte; the byte then passes weight,
// multiply and accumulate stages. A row-end byte closes input until its sum lands
// in the output register, after the pipeline and, in min/max format, the radix-16
// divide by 15. Synchronous reset; no clearing pass. A held result stalls input
// only once the next row's last byte is in.
`default_nettype none

`include "q4_block_quantized_matvec_assert.svh"

module q4_block_quantized_matvec (
  input  logic                              clk,
  input  logic                              rst,
  q4mv_item_if.sink                         items,
  q4mv_result_if.source                     results,
  input  logic                              cfg_write,
  input  logic [q4mv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [q4mv_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW  = q4mv_pkg::ACC_W;
  localparam int WW  = q4mv_pkg::WEIGHT_W;
  localparam int PW  = q4mv_pkg::PROD_W;
  localparam int VW  = q4mv_pkg::VAL_W;
  localparam int RW  = q4mv_pkg::ROW_W;
  localparam int BW  = q4mv_pkg::BPR_W;
  localparam int DB  = q4mv_pkg::DIV_BITS;
  localparam int CW  = q4mv_pkg::DIV_CNT_W;
  localparam int PAIR_AW = q4mv_pkg::ACT_IDX_W - 1;
  localparam int PAIRS   = 1 << PAIR_AW;

  typedef enum logic [1:0] {FIN_IDLE, FIN_DIV, FIN_HOLD} fin_state_t;

  // configuration
  logic          cfg_format;
  logic [BW-1:0] cfg_bpr;
  logic [RW-1:0] cfg_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_format <= 1'b0;
      cfg_bpr    <= BW'(1);
      cfg_rows   <= RW'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        q4mv_pkg::REG_FORMAT:         cfg_format <= cfg_data[0];
        q4mv_pkg::REG_BLOCKS_PER_ROW: cfg_bpr    <= cfg_data[BW-1:0];
        q4mv_pkg::REG_ROWS_IN_USE:    cfg_rows   <= cfg_data[RW-1:0];
        default: ;
      endcase
    end
  end

  // input side
  logic                row_pending;
  logic                in_fire;
  logic                is_load, is_scales, is_weight;
  logic [3:0]          byte_pos;
  logic [7:0]          block_pos;
  logic [RW-1:0]       row_counter;
  logic signed [VW-1:0] scale_a, scale_b;
  logic [BW-1:0]       bpr_eff;
  logic [RW-1:0]       rows_eff;
  logic                byte_wrap, block_wrap, row_end, row_last;
  logic [PAIR_AW-1:0]  pair_addr;

  assign items.ready = !row_pending;
  assign in_fire     = items.valid && items.ready;

  always_comb begin
    is_load   = 1'b0;
    is_scales = 1'b0;
    is_weight = 1'b0;
    case (items.command)
      q4mv_pkg::CMD_LOAD_ACT: is_load   = 1'b1;
      q4mv_pkg::CMD_SCALES:   is_scales = 1'b1;
      q4mv_pkg::CMD_WEIGHT:   is_weight = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    if (cfg_bpr == '0) begin
      bpr_eff = BW'(1);
    end else if (cfg_bpr > BW'(q4mv_pkg::MAX_BLOCKS)) begin
      bpr_eff = BW'(q4mv_pkg::MAX_BLOCKS);
    end else begin
      bpr_eff = cfg_bpr;
    end
    rows_eff   = (cfg_rows == '0) ? RW'(1) : cfg_rows;
    byte_wrap  = (byte_pos == 4'(q4mv_pkg::BYTES_PER_BLOCK - 1));
    block_wrap = !(({1'b0, block_pos} + BW'(1)) < bpr_eff);
    row_end    = byte_wrap && block_wrap;
    row_last   = (({1'b0, row_counter} + (RW+1)'(1)) >= {1'b0, rows_eff});
    pair_addr  = {block_pos, byte_pos};
  end

  // tag of the row now closing
  logic          end_fmt_unused;
  logic [RW-1:0] end_row;
  logic          end_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos    <= '0;
      block_pos   <= '0;
      row_counter <= '0;
      scale_a     <= '0;
      scale_b     <= '0;
    end else if (in_fire) begin
      if (is_scales) begin
        scale_a <= items.scale_first;
        scale_b <= items.scale_second;
      end
      if (is_weight) begin
        byte_pos <= byte_wrap ? 4'd0 : byte_pos + 4'd1;
        if (byte_wrap) begin
          block_pos <= block_wrap ? 8'd0 : block_pos + 8'd1;
        end
        if (row_end) begin
          row_counter <= row_last ? '0 : row_counter + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_weight && row_end) begin
      end_row  <= row_counter;
      end_last <= row_last;
    end
  end
  assign end_fmt_unused = 1'b0;

  // activation store: even and odd elements of each pair
  logic signed [VW-1:0] act_even [PAIRS];
  logic signed [VW-1:0] act_odd  [PAIRS];
  logic signed [VW-1:0] x_even, x_odd;

  always_ff @(posedge clk) begin
    if (in_fire && is_load) begin
      if (items.act_index[0]) begin
        act_odd[items.act_index[PAIR_AW:1]] <= items.act_value;
      end else begin
        act_even[items.act_index[PAIR_AW:1]] <= items.act_value;
      end
    end
    if (in_fire && is_weight) begin
      x_even <= act_even[pair_addr];
      x_odd  <= act_odd[pair_addr];
    end
  end

  // stage 1: nibbles and scales, RAM data arrives
  logic                 s1_valid, s1_end, s1_fmt;
  logic [3:0]           s1_q0, s1_q1;
  logic signed [VW-1:0] s1_sa, s1_sb;
  // stage 2: weights
  logic                 s2_valid, s2_end;
  logic signed [WW-1:0] s2_w0, s2_w1;
  logic signed [VW-1:0] s2_x0, s2_x1;
  // stage 3: products
  logic                 s3_valid, s3_end;
  logic signed [PW-1:0] s3_p0, s3_p1;

  function automatic logic signed [WW-1:0] elem_weight(
    input logic [3:0] q, input logic signed [VW-1:0] sa,
    input logic signed [VW-1:0] sb, input logic fmt
  );
    logic signed [WW-1:0] qs, a, b, r;
    qs = signed'(WW'(q));
    a  = WW'(sa);
    b  = WW'(sb);
    if (fmt) begin
      r = WW'(q4mv_pkg::MINMAX_DIV) * a + qs * (b - a);
    end else begin
      r = (qs - WW'(q4mv_pkg::SYM_OFFSET)) * a;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire && is_weight;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_weight) begin
      s1_q0  <= items.weight_byte[3:0];
      s1_q1  <= items.weight_byte[7:4];
      s1_sa  <= scale_a;
      s1_sb  <= scale_b;
      s1_fmt <= cfg_format;
      s1_end <= row_end;
    end
    s2_w0  <= elem_weight(s1_q0, s1_sa, s1_sb, s1_fmt);
    s2_w1  <= elem_weight(s1_q1, s1_sa, s1_sb, s1_fmt);
    s2_x0  <= x_even;
    s2_x1  <= x_odd;
    s2_end <= s1_end;
    s3_p0  <= PW'(s2_w0) * PW'(s2_x0);
    s3_p1  <= PW'(s2_w1) * PW'(s2_x1);
    s3_end <= s2_end;
  end

  // accumulate
  logic [AW-1:0] acc, acc_sum;

  assign acc_sum = acc + {{(AW-PW){s3_p0[PW-1]}}, s3_p0}
                       + {{(AW-PW){s3_p1[PW-1]}}, s3_p1};

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (s3_valid) begin
      acc <= s3_end ? '0 : acc_sum;
    end
  end

  // format in force at the row's last byte
  logic s3_fmt, s2_fmt, s1_fmt_at_end;
  always_ff @(posedge clk) begin
    s2_fmt <= s1_fmt;
    s3_fmt <= s2_fmt;
  end
  assign s1_fmt_at_end = s3_fmt || end_fmt_unused;

  // row finish: optional divide by 15 toward zero, then output register
  fin_state_t     fin_state;
  logic [AW-1:0]  fin_dvd, dvd_next, fin_signed;
  logic [3:0]     fin_rem, rem_next;
  logic           fin_neg;
  logic [CW-1:0]  fin_count;
  logic           fin_start, fin_load;

  always_comb begin
    logic [4:0] r5;
    dvd_next = fin_dvd;
    rem_next = fin_rem;
    for (int i = 0; i < DB; i++) begin
      r5       = {rem_next, dvd_next[AW-1]};
      dvd_next = {dvd_next[AW-2:0], 1'b0};
      if (r5 >= 5'(q4mv_pkg::MINMAX_DIV)) begin
        rem_next    = 4'(r5 - 5'(q4mv_pkg::MINMAX_DIV));
        dvd_next[0] = 1'b1;
      end else begin
        rem_next = r5[3:0];
      end
    end
  end

  assign fin_start  = s3_valid && s3_end;
  assign fin_load   = (fin_state == FIN_HOLD) && (!results.valid || results.ready);
  assign fin_signed = fin_neg ? (AW'(0) - fin_dvd) : fin_dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_state     <= FIN_IDLE;
      results.valid <= 1'b0;
    end else begin
      if (fin_load) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
      case (fin_state)
        FIN_IDLE: begin
          if (fin_start) begin
            fin_rem   <= '0;
            fin_count <= '0;
            if (s1_fmt_at_end) begin
              fin_neg   <= acc_sum[AW-1];
              fin_dvd   <= acc_sum[AW-1] ? (AW'(0) - acc_sum) : acc_sum;
              fin_state <= FIN_DIV;
            end else begin
              fin_neg   <= 1'b0;
              fin_dvd   <= acc_sum;
              fin_state <= FIN_HOLD;
            end
          end
        end
        FIN_DIV: begin
          fin_dvd   <= dvd_next;
          fin_rem   <= rem_next;
          fin_count <= fin_count + CW'(1);
          if (fin_count == CW'(q4mv_pkg::DIV_STEPS - 1)) begin
            fin_state <= FIN_HOLD;
          end
        end
        FIN_HOLD: begin
          if (fin_load) begin
            results.row_sum   <= fin_signed[q4mv_pkg::SUM_W-1:0];
            results.row_index <= end_row;
            results.last_row  <= end_last;
            fin_state         <= FIN_IDLE;
          end
        end
        default: fin_state <= FIN_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pending <= 1'b0;
    end else if (in_fire && is_weight && row_end) begin
      row_pending <= 1'b1;
    end else if (fin_load) begin
      row_pending <= 1'b0;
    end
  end

  `Q4MV_ASSERT_SAME(a_start_idle, clk, rst, fin_start, fin_state == FIN_IDLE)
  `Q4MV_ASSERT_SAME(a_quiet_when_free, clk, rst, !row_pending,
    !(s1_valid && s1_end) && !(s2_valid && s2_end) && !(s3_valid && s3_end) &&
    fin_state == FIN_IDLE)
  `Q4MV_ASSERT_SAME(a_release_has_result, clk, rst, $fell(row_pending),
    results.valid)
  `Q4MV_ASSERT_NEXT(a_div_runs, clk, rst,
    fin_state == FIN_DIV && fin_count != CW'(q4mv_pkg::DIV_STEPS - 1),
    fin_state == FIN_DIV)
  `Q4MV_ASSERT_NEXT(a_row_end_locks, clk, rst, in_fire && is_weight && row_end,
    row_pending)

endmodule

`default_nettype wire

@@ sim/tb_q4_block_quantized_matvec.sv @@
// Self-checking bench for the 4-bit block matvec: directed table, random matrices, row sum predictor.
`default_nettype none

module tb_q4_block_quantized_matvec;
  import q4mv_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int ACT_DEPTH = 8192;
  localparam int BLOCK_ELEMS = 32;
  localparam int RANDOM_ITEMS = 1800;
  localparam int CALM_AFTER = 1550;
  localparam int DRAIN_CYCLES = 32;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [ACT_IDX_W-1:0] act_index;
    logic signed [15:0]   act_value;
    logic signed [15:0]   scale_first;
    logic signed [15:0]   scale_second;
    logic [BYTE_W-1:0]    weight_byte;
  } item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] row_sum;
    logic [ROW_W-1:0]        row_index;
    logic                    last_row;
  } row_t;

  typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_t;

  // For a register write, command holds the register index and value its data.
  typedef struct packed {
    step_kind_t              kind;
    logic [CMD_W-1:0]        command;
    logic [ACT_IDX_W-1:0]    act_index;
    logic [15:0]             value;
    logic [15:0]             second;
    logic [BYTE_W-1:0]       weight_byte;
    logic [5:0]              reps;
    logic                    typed;
    logic signed [SUM_W-1:0] want_sum;
    logic [ROW_W-1:0]        want_index;
    logic                    want_last;
  } dir_step_t;

  // Starts in format 0, one block per row, one row.
  localparam int N_DIR = 25;
  dir_step_t dir_table [N_DIR] = '{
    // kind, cmd/reg, index, value, second, byte, reps, typed, sum, row, last
    '{STEP_ITEM, CMD_LOAD_ACT, 0, 'h1000, 0, 0, 32, 0, 0, 0, 0},
    '{STEP_ITEM, CMD_SCALES, 0, 'h4000, 0, 0, 1, 0, 0, 0, 0},
    '{STEP_ITEM, CMD_WEIGHT, 0, 0, 0, 'h88, 16, 1, 0, 0, 1},
    '{STEP_ITEM, CMD_WEIGHT, 0, 0, 0, 'h99, 16, 1, 'h8000_0000, 0, 1},
    '{STEP_ITEM, CMD_LOAD_ACT, 0, 'h8000, 0, 0, 1, 0, 0, 0, 0},
    '{STEP_ITEM, CMD_LOAD_ACT, 1, 'h7FFF, 0, 0, 1, 0, 0, 0, 0},
    '{STEP_ITEM, CMD_UNUSED, 'h1FFF, 'hFFFF, 'hFFFF, 'hFF, 1, 0, 0, 0, 0},
    '{STEP_ITEM, CMD_SCALES, 0, 'h8000, 'h7FFF, 0, 1, 0, 0, 0, 0},
    '{STEP_ITEM, CMD_WEIGHT, 0, 0, 0, 'h0F, 1, 0, 0, 0, 0},
    '{STEP_ITEM, CMD_WEIGHT, 0, 0, 0, 'hF0, 7, 0, 0, 0, 0},
    '{STEP_ITEM, CMD_SCALES, 0, 'h7FFF, 'h8000, 0, 1, 0, 0, 0, 0},
    '{STEP_ITEM, CMD_WEIGHT, 0, 0, 0, 'h00, 4, 0, 0, 0, 0},
    '{STEP_ITEM, CMD_WEIGHT, 0, 0, 0, 'hFF, 4, 0, 0, 0, 0},
    '{STEP_CFG, REG_FORMAT, 0, 1, 0, 0, 1, 0, 0, 0, 0},
    '{STEP_CFG, REG_ROWS_IN_USE, 0, 2, 0, 0, 1, 0, 0, 0, 0},
    '{STEP_ITEM, CMD_SCALES, 0, 0, 0, 0, 1, 0, 0, 0, 0},
    '{STEP_ITEM, CMD_WEIGHT, 0, 0, 0, 'hFF, 16, 1, 0, 0, 0},
    '{STEP_ITEM, CMD_SCALES, 0, 'h8000, 'h7FFF, 0, 1, 0, 0, 0, 0},
    '{STEP_ITEM, CMD_WEIGHT, 0, 0, 0, 'hA5, 16, 0, 0, 0, 0},
    '{STEP_CFG, REG_BLOCKS_PER_ROW, 0, 0, 0, 0, 1, 0, 0, 0, 0},
    '{STEP_CFG, REG_ROWS_IN_USE, 0, 0, 0, 0, 1, 0, 0, 0, 0},
    '{STEP_ITEM, CMD_WEIGHT, 0, 0, 0, 'h3C, 16, 0, 0, 0, 0},
    '{STEP_CFG, REG_FORMAT, 0, 0, 0, 0, 1, 0, 0, 0, 0},
    '{STEP_CFG, REG_BLOCKS_PER_ROW, 0, 'h1FF, 0, 0, 1, 0, 0, 0, 0},
    '{STEP_CFG, REG_ROWS_IN_USE, 0, 'hFFFF, 0, 0, 1, 0, 0, 0, 0}
  };

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  q4mv_item_if item_bus ();
  q4mv_result_if row_bus ();

  q4_block_quantized_matvec i_dut (
    .clk       (clk),
    .rst       (rst),
    .items     (item_bus),
    .results   (row_bus),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Shadow of the block's state and registers
  logic signed [15:0] act_mem [ACT_DEPTH];
  bit act_known [ACT_DEPTH];
  int pair_pos;
  int blk_pos;
  int row_cnt;
  logic signed [15:0] scl_a;
  logic signed [15:0] scl_b;
  logic signed [ACC_W-1:0] dot_acc;
  logic cur_fmt;
  logic [BPR_W-1:0] cur_bpr;
  logic [ROW_W-1:0] cur_rows;

  row_t expected_rows [$];
  int fail_count;
  int item_total;
  bit calm;
  int quiet_cycles;
  int sink_hold;

  function automatic longint elem_term(input logic [3:0] q, input int idx);
    longint w;
    longint x;
    x = act_mem[idx % ACT_DEPTH];
    if (cur_fmt == 1'b0)
      w = (longint'(q) - SYM_OFFSET) * longint'(scl_a);
    else
      w = MINMAX_DIV * longint'(scl_a) + longint'(q) * (longint'(scl_b) - longint'(scl_a));
    return w * x;
  endfunction

  function automatic bit advance_matvec(input item_t it, output row_t row);
    int base;
    int bpr_eff;
    int rows_eff;
    longint s;
    bit last;
    row = '0;
    case (it.command)
      CMD_LOAD_ACT: begin
        act_mem[it.act_index] = it.act_value;
        act_known[it.act_index] = 1'b1;
        return 1'b0;
      end
      CMD_SCALES: begin
        scl_a = it.scale_first;
        scl_b = it.scale_second;
        return 1'b0;
      end
      CMD_WEIGHT: ;
      default: return 1'b0;
    endcase
    base = blk_pos * BLOCK_ELEMS + pair_pos * 2;
    dot_acc = dot_acc + ACC_W'(elem_term(it.weight_byte[3:0], base))
                      + ACC_W'(elem_term(it.weight_byte[7:4], base + 1));
    if (pair_pos < BYTES_PER_BLOCK - 1) begin
      pair_pos++;
      return 1'b0;
    end
    pair_pos = 0;
    bpr_eff = (cur_bpr == 0) ? 1 : ((cur_bpr > MAX_BLOCKS) ? MAX_BLOCKS : int'(cur_bpr));
    if (blk_pos + 1 < bpr_eff) begin
      blk_pos++;
      return 1'b0;
    end
    blk_pos = 0;
    s = dot_acc;
    if (cur_fmt)
      s = s / MINMAX_DIV;
    rows_eff = (cur_rows == 0) ? 1 : int'(cur_rows);
    last = (row_cnt + 1 >= rows_eff);
    row.row_sum = s[SUM_W-1:0];
    row.row_index = row_cnt[ROW_W-1:0];
    row.last_row = last;
    row_cnt = last ? 0 : ((row_cnt + 1) % 65536);
    dot_acc = '0;
    return 1'b1;
  endfunction

  task automatic push_item(input item_t it, input bit typed, input row_t want,
                           output bit made_row);
    row_t row;
    cfg_write <= 1'b0;
    if (!calm && $urandom_range(0, 7) == 0) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    item_bus.valid <= 1'b1;
    item_bus.command <= it.command;
    item_bus.act_index <= it.act_index;
    item_bus.act_value <= it.act_value;
    item_bus.scale_first <= it.scale_first;
    item_bus.scale_second <= it.scale_second;
    item_bus.weight_byte <= it.weight_byte;
    do @(posedge clk); while (item_bus.ready !== 1'b1);
    made_row = advance_matvec(it, row);
    if (made_row)
      expected_rows.push_back(typed ? want : row);
    if (it.command != CMD_UNUSED)
      item_total++;
  endtask

  // Drop valid, wait for every pending row, then let the pipeline drain.
  task automatic settle();
    item_bus.valid <= 1'b0;
    cfg_write <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data <= data;
    @(posedge clk);
    case (sel)
      REG_FORMAT:         cur_fmt = data[0];
      REG_BLOCKS_PER_ROW: cur_bpr = data[BPR_W-1:0];
      REG_ROWS_IN_USE:    cur_rows = data[ROW_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [15:0] pick16();
    if ($urandom_range(0, 7) == 0)
      case ($urandom_range(0, 3))
        0: return 16'h8000;
        1: return 16'h7FFF;
        2: return 16'h0000;
        default: return 16'hFFFF;
      endcase
    return 16'($urandom);
  endfunction

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 7) == 0)
      case ($urandom_range(0, 2))
        0: return 8'h00;
        1: return 8'hFF;
        default: return 8'h88;
      endcase
    return 8'($urandom);
  endfunction

  task automatic send_random(input logic [CMD_W-1:0] cmd, input int idx, output bit made_row);
    item_t it;
    it.command = cmd;
    it.act_index = idx[ACT_IDX_W-1:0];
    it.act_value = pick16();
    it.scale_first = pick16();
    it.scale_second = pick16();
    it.weight_byte = pick_byte();
    push_item(it, 1'b0, '0, made_row);
  endtask

  task automatic ensure_act(input int idx);
    bit made;
    if (!act_known[idx])
      send_random(CMD_LOAD_ACT, idx, made);
  endtask

  task automatic run_phase();
    int rows_goal;
    int done;
    int base;
    int r;
    bit made;
    settle();
    write_reg(REG_FORMAT, 16'($urandom_range(0, 1)));
    r = $urandom_range(0, 9);
    if (r == 0)
      write_reg(REG_BLOCKS_PER_ROW, 16'd0);
    else if (r <= 6)
      write_reg(REG_BLOCKS_PER_ROW, 16'($urandom_range(1, 3)));
    else
      write_reg(REG_BLOCKS_PER_ROW, 16'($urandom_range(4, 8)));
    r = $urandom_range(0, 9);
    if (r == 0)
      write_reg(REG_ROWS_IN_USE, 16'd0);
    else if (r == 1)
      write_reg(REG_ROWS_IN_USE, 16'hFFFF);
    else if (r <= 7)
      write_reg(REG_ROWS_IN_USE, 16'($urandom_range(1, 4)));
    else
      write_reg(REG_ROWS_IN_USE, 16'($urandom_range(1, 65535)));
    rows_goal = $urandom_range(1, 3);
    done = 0;
    while (done < rows_goal) begin
      if (pair_pos == 0 && $urandom_range(0, 9) != 0)
        send_random(CMD_SCALES, 0, made);
      r = $urandom_range(0, 39);
      if (r == 0) begin
        send_random(CMD_UNUSED, $urandom_range(0, ACT_DEPTH - 1), made);
      end else if (r == 1) begin
        send_random(CMD_LOAD_ACT, $urandom_range(0, ACT_DEPTH - 1), made);
      end else if (r == 2) begin
        send_random(CMD_SCALES, 0, made);
      end else if (r == 3) begin
        // change a register in the middle of the row
        settle();
        case ($urandom_range(0, 2))
          0: write_reg(REG_FORMAT, 16'($urandom_range(0, 1)));
          1: write_reg(REG_BLOCKS_PER_ROW, 16'($urandom_range(0, 4)));
          default: write_reg(REG_ROWS_IN_USE,
                             $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom_range(0, 4)));
        endcase
      end
      base = blk_pos * BLOCK_ELEMS + pair_pos * 2;
      ensure_act(base);
      ensure_act(base + 1);
      send_random(CMD_WEIGHT, 0, made);
      if (made)
        done++;
    end
  endtask

  // Result sink: check each transfer and stall in short bursts.
  always @(posedge clk) begin
    row_t exp_row;
    if (rst) begin
      row_bus.ready <= 1'b0;
      sink_hold = 0;
    end else begin
      if (row_bus.valid === 1'b1 && row_bus.ready === 1'b1) begin
        if (expected_rows.size() == 0) begin
          $error("unexpected row result: row_sum %0d, row_index %0d",
                 row_bus.row_sum, row_bus.row_index);
          fail_count++;
        end else begin
          exp_row = expected_rows.pop_front();
          if (row_bus.row_sum !== exp_row.row_sum) begin
            $error("row_sum: expected %0d, got %0d", exp_row.row_sum, row_bus.row_sum);
            fail_count++;
          end
          if (row_bus.row_index !== exp_row.row_index) begin
            $error("row_index: expected %0d, got %0d", exp_row.row_index, row_bus.row_index);
            fail_count++;
          end
          if (row_bus.last_row !== exp_row.last_row) begin
            $error("last_row: expected %0d, got %0d", exp_row.last_row, row_bus.last_row);
            fail_count++;
          end
        end
      end
      if (calm) begin
        row_bus.ready <= 1'b1;
      end else if (sink_hold > 0) begin
        row_bus.ready <= 1'b0;
        sink_hold--;
      end else if ($urandom_range(0, 7) == 0) begin
        row_bus.ready <= 1'b0;
        sink_hold = $urandom_range(0, 2);
      end else begin
        row_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_bus.valid === 1'b1 && item_bus.ready === 1'b1)
        || (row_bus.valid === 1'b1 && row_bus.ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    dir_step_t st;
    item_t it;
    row_t want;
    bit made;
    int r;
    int start_total;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_FORMAT;
    cfg_data = '0;
    item_bus.valid = 1'b0;
    item_bus.command = CMD_LOAD_ACT;
    item_bus.act_index = '0;
    item_bus.act_value = '0;
    item_bus.scale_first = '0;
    item_bus.scale_second = '0;
    item_bus.weight_byte = '0;
    row_bus.ready = 1'b0;
    pair_pos = 0;
    blk_pos = 0;
    row_cnt = 0;
    scl_a = '0;
    scl_b = '0;
    dot_acc = '0;
    cur_fmt = 1'b0;
    cur_bpr = 1;
    cur_rows = 1;
    fail_count = 0;
    item_total = 0;
    calm = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_table[i]) begin
      st = dir_table[i];
      if (st.kind == STEP_CFG) begin
        settle();
        write_reg(cfg_reg_t'(st.command), st.value);
      end else begin
        for (r = 0; r < st.reps; r++) begin
          it.command = st.command;
          it.act_index = st.act_index + ACT_IDX_W'(r);
          it.act_value = st.value;
          it.scale_first = st.value;
          it.scale_second = st.second;
          it.weight_byte = st.weight_byte;
          want.row_sum = st.want_sum;
          want.row_index = st.want_index;
          want.last_row = st.want_last;
          push_item(it, st.typed, want, made);
        end
      end
    end

    start_total = item_total;
    while (item_total - start_total < RANDOM_ITEMS) begin
      calm = (item_total - start_total >= CALM_AFTER);
      run_phase();
    end

    item_bus.valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/q4mv_pkg.sv
rtl/q4mv_if.sv
rtl/q4_block_quantized_matvec.sv
sim/tb_q4_block_quantized_matvec.sv
